// ----- rtl/core/reading_cache_with_ttl_aging_macros.svh -----
// ----------------------------------------------------------------------------
// Reading cache assertion macros
// Shared property forms for the reading cache checkers.
// ----------------------------------------------------------------------------
`ifndef READING_CACHE_WITH_TTL_AGING_MACROS_SVH
`define READING_CACHE_WITH_TTL_AGING_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCTTL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reading cache check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCTTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reading cache check failed");

`endif

// ----- rtl/core/rcttl_pkg.sv -----
// ----------------------------------------------------------------------------
// Reading cache package
// Shared constants, codes and interface types of the reading cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcttl_pkg;

  localparam int ENTRIES = 128;
  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] MODE_STORE = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] CFG_TTL_INITIAL = 2'd0;
  localparam logic [1:0] CFG_TTL_STEP    = 2'd1;
  localparam logic [1:0] CFG_TICK_DIVIDE = 2'd2;

  localparam logic [7:0] TTL_INITIAL_RESET = 8'd250;
  localparam logic [7:0] TTL_STEP_RESET    = 8'd100;
  localparam logic [9:0] TICK_DIVIDE_RESET = 10'd624;

  localparam logic [7:0] PACKET_TYPE_DATA = 8'h00;

  // Division by 100 of a 16-bit word: multiply by ceil(2^23 / 100), shift by 23.
  localparam int          DIV100_SHIFT = 23;
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam logic [6:0]  SCALE        = 7'd100;

  typedef struct packed {
    logic              en;
    logic              full;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        ttl;
    logic [7:0]        cur;
    logic [9:0]        volt;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0] ttl;
    logic [7:0] cur;
    logic [9:0] volt;
  } mem_rd_t;

endpackage

// ----- rtl/core/rcttl_mem.sv -----
// ----------------------------------------------------------------------------
// Reading cache entry memory
// Time-to-live, current and voltage arrays with per-entry valid bits, one
// registered read port and one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcttl_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [rcttl_pkg::ADDR_W-1:0] rd_addr,
  output rcttl_pkg::mem_rd_t          rd_data,
  input  rcttl_pkg::mem_wr_t          wr
);

  logic [7:0] ttl_mem [rcttl_pkg::ENTRIES];
  logic [7:0] cur_mem [rcttl_pkg::ENTRIES];
  logic [9:0] volt_mem [rcttl_pkg::ENTRIES];
  logic [rcttl_pkg::ENTRIES-1:0] valid;

  logic       rd_valid;
  logic [7:0] rd_ttl;
  logic [7:0] rd_cur;
  logic [9:0] rd_volt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ttl_mem[wr.addr] <= wr.ttl;
      if (wr.full) begin
        cur_mem[wr.addr] <= wr.cur;
        volt_mem[wr.addr] <= wr.volt;
      end
    end
    if (rd_en) begin
      rd_ttl <= ttl_mem[rd_addr];
      rd_cur <= cur_mem[rd_addr];
      rd_volt <= volt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en && wr.full) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data.ttl = rd_valid ? rd_ttl : 8'd0;
  assign rd_data.cur = rd_valid ? rd_cur : 8'd0;
  assign rd_data.volt = rd_valid ? rd_volt : 10'd0;

endmodule

// ----- rtl/core/reading_cache_with_ttl_aging.sv -----
// A query's result is registered behind stage-one and memory read registers.
// No new request is taken while busy; busy is high for the cycle in which
// the entry read in the accept cycle is modified and written back.
// Stores and ticks give no result. The receiver cannot stall results.
// Reset clears the valid bits of all entries, the sweep pointer, the prescaler
// and the pipeline, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Reading cache with time-to-live aging
// Per-node measurement cache with store, aging tick and query requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reading_cache_with_ttl_aging (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [6:0]  node_id,
  input  logic [15:0] current_raw,
  input  logic [15:0] voltage_raw,
  input  logic [7:0]  packet_type,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        result_valid,
  output logic        hit,
  output logic [6:0]  node_id_out,
  output logic [14:0] current_scaled,
  output logic [15:0] voltage_scaled
);

  logic [7:0] ttl_initial;
  logic [7:0] ttl_step;
  logic [9:0] tick_divide;

  logic [rcttl_pkg::ADDR_W-1:0] sweep_pointer;
  logic [rcttl_pkg::ADDR_W-1:0] sweep_pointer_next;
  logic [9:0] tick_prescaler;
  logic [9:0] prescaler_inc;
  logic       wrap;

  logic accept;
  logic id_ok;
  logic [rcttl_pkg::ADDR_W-1:0] rd_addr;

  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic [6:0]  s1_id;
  logic        s1_id_ok;
  logic        s1_data_ok;
  logic        s1_age;
  logic [rcttl_pkg::ADDR_W-1:0] s1_addr;
  logic [15:0] s1_cur;
  logic [15:0] s1_volt;

  rcttl_pkg::mem_rd_t rd_data;
  rcttl_pkg::mem_wr_t wr;

  logic [32:0] cur_prod;
  logic [32:0] volt_prod;
  logic [14:0] cur_scale;
  logic [15:0] volt_scale;
  logic        s1_hit;
  logic [7:0]  aged_ttl;

  assign cfg_ready = 1'b1;
  assign busy = s1_valid;
  assign accept = start && !busy;
  assign id_ok = 32'(node_id) < rcttl_pkg::ENTRIES;

  assign prescaler_inc = tick_prescaler + 10'd1;
  assign wrap = prescaler_inc >= tick_divide;
  assign sweep_pointer_next = (sweep_pointer == rcttl_pkg::ADDR_W'(rcttl_pkg::ENTRIES - 1))
                              ? '0 : sweep_pointer + rcttl_pkg::ADDR_W'(1);
  assign rd_addr = (mode == rcttl_pkg::MODE_TICK) ? sweep_pointer
                                                  : rcttl_pkg::ADDR_W'(node_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_initial <= rcttl_pkg::TTL_INITIAL_RESET;
      ttl_step <= rcttl_pkg::TTL_STEP_RESET;
      tick_divide <= rcttl_pkg::TICK_DIVIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcttl_pkg::CFG_TTL_INITIAL: ttl_initial <= cfg_data[7:0];
        rcttl_pkg::CFG_TTL_STEP:    ttl_step <= cfg_data[7:0];
        rcttl_pkg::CFG_TICK_DIVIDE: tick_divide <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      sweep_pointer <= '0;
      tick_prescaler <= '0;
    end else begin
      s1_valid <= accept;
      if (accept && mode == rcttl_pkg::MODE_TICK) begin
        if (wrap) begin
          tick_prescaler <= '0;
          sweep_pointer <= sweep_pointer_next;
        end else begin
          tick_prescaler <= prescaler_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= mode;
      s1_id <= node_id;
      s1_id_ok <= id_ok;
      s1_data_ok <= packet_type == rcttl_pkg::PACKET_TYPE_DATA;
      s1_age <= wrap;
      s1_addr <= rd_addr;
      s1_cur <= current_raw;
      s1_volt <= voltage_raw;
    end
  end

  rcttl_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign cur_prod = 33'(s1_cur) * 33'(rcttl_pkg::DIV100_MUL);
  assign volt_prod = 33'(s1_volt) * 33'(rcttl_pkg::DIV100_MUL);
  assign aged_ttl = (rd_data.ttl >= ttl_step) ? rd_data.ttl - ttl_step : 8'd0;

  always_comb begin
    wr = '0;
    wr.addr = s1_addr;
    wr.cur = cur_prod[rcttl_pkg::DIV100_SHIFT +: 8];
    wr.volt = volt_prod[rcttl_pkg::DIV100_SHIFT +: 10];
    wr.ttl = ttl_initial;
    if (s1_valid) begin
      case (s1_mode)
        rcttl_pkg::MODE_STORE: begin
          wr.en = s1_data_ok && s1_id_ok;
          wr.full = 1'b1;
        end
        rcttl_pkg::MODE_TICK: begin
          wr.en = s1_age && (rd_data.ttl != 8'd0);
          wr.ttl = aged_ttl;
        end
        default: begin
        end
      endcase
    end
  end

  assign s1_hit = s1_id_ok && (rd_data.ttl != 8'd0);
  assign cur_scale = 15'(rd_data.cur) * 15'(rcttl_pkg::SCALE);
  assign volt_scale = 16'(rd_data.volt) * 16'(rcttl_pkg::SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s1_valid && (s1_mode == rcttl_pkg::MODE_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_mode == rcttl_pkg::MODE_QUERY) begin
      hit <= s1_hit;
      node_id_out <= s1_id;
      current_scaled <= s1_hit ? cur_scale : 15'd0;
      voltage_scaled <= s1_hit ? volt_scale : 16'd0;
    end
  end

endmodule

// ----- rtl/core/rcttl_checker.sv -----
// ----------------------------------------------------------------------------
// Reading cache port checker
// Checks request and result timing seen on the reading cache ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reading_cache_with_ttl_aging_macros.svh"

module rcttl_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  mode,
  input logic [6:0]  node_id,
  input logic        result_valid,
  input logic        hit,
  input logic [6:0]  node_id_out,
  input logic [14:0] current_scaled,
  input logic [15:0] voltage_scaled
);

  logic accept;
  logic query_accept;

  assign accept = start && !busy;
  assign query_accept = accept && (mode == rcttl_pkg::MODE_QUERY);

  `RCTTL_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, busy)
  `RCTTL_ASSERT_NEXT(a_busy_one_cycle, clk, rst, busy, !busy)
  `RCTTL_ASSERT_SAME(a_result_from_query, clk, rst,
                     result_valid && !$past(rst, 2),
                     $past(query_accept, 2) && node_id_out == $past(node_id, 2))
  `RCTTL_ASSERT_SAME(a_miss_zero, clk, rst, result_valid && !hit,
                     current_scaled == 15'd0 && voltage_scaled == 16'd0)

endmodule

bind reading_cache_with_ttl_aging rcttl_checker u_rcttl_checker (.*);

// ----- test/reading_cache_with_ttl_aging_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reading cache with time-to-live aging testbench
// Drives store, tick and query requests and checks every query reply against
// the values its directed row gives, if any, else a shadow copy of the cache
// kept in the testbench. A short table of directed requests comes first.
// Random requests follow under several register settings, extremes included.
// ----------------------------------------------------------------------------

module reading_cache_with_ttl_aging_tb;
  import rcttl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    logic        hit;
    logic [6:0]  node;
    logic [14:0] cur;
    logic [15:0] volt;
  } reply_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  node;
    logic [15:0] cur;
    logic [15:0] volt;
    logic [7:0]  ptype;
    logic        typed;
    reply_t      want;
  } req_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [6:0]  node_id;
  logic [15:0] current_raw;
  logic [15:0] voltage_raw;
  logic [7:0]  packet_type;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        result_valid;
  logic        hit;
  logic [6:0]  node_id_out;
  logic [14:0] current_scaled;
  logic [15:0] voltage_scaled;

  logic [7:0]        shadow_ttl [ENTRIES];
  logic [7:0]        shadow_cur [ENTRIES];
  logic [9:0]        shadow_volt [ENTRIES];
  logic [ADDR_W-1:0] shadow_ptr;
  logic [9:0]        shadow_presc;
  logic [7:0]        shadow_ttl_init;
  logic [7:0]        shadow_step;
  logic [9:0]        shadow_div;

  reply_t   pending_replies [$];
  reply_t   want;
  req_row_t script [$];
  int       fault_count;
  int       idle_cycles;

  reading_cache_with_ttl_aging dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .node_id(node_id),
    .current_raw(current_raw),
    .voltage_raw(voltage_raw),
    .packet_type(packet_type),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .hit(hit),
    .node_id_out(node_id_out),
    .current_scaled(current_scaled),
    .voltage_scaled(voltage_scaled)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_row_t row(logic [1:0] m, logic [6:0] id, logic [15:0] c,
                                   logic [15:0] v, logic [7:0] t, logic typed = 1'b0,
                                   logic h = 1'b0, logic [14:0] cs = '0,
                                   logic [15:0] vs = '0);
    req_row_t r;
    r.mode = m;
    r.node = id;
    r.cur = c;
    r.volt = v;
    r.ptype = t;
    r.typed = typed;
    r.want = '{hit: h, node: id, cur: cs, volt: vs};
    return r;
  endfunction

  // Updates the shadow cache for one request; returns 1 when a reply is due.
  function automatic bit cache_update(req_row_t rq, output reply_t r);
    logic [7:0] t;
    r = '{hit: 1'b0, node: rq.node, cur: '0, volt: '0};
    case (rq.mode)
      MODE_STORE: begin
        if (rq.ptype == PACKET_TYPE_DATA) begin
          shadow_ttl[rq.node] = shadow_ttl_init;
          shadow_cur[rq.node] = 8'((rq.cur / 16'd100) & 16'hFF);
          shadow_volt[rq.node] = 10'(rq.volt / 16'd100);
        end
        return 1'b0;
      end
      MODE_TICK: begin
        shadow_presc = shadow_presc + 10'd1;
        if (shadow_presc >= shadow_div) begin
          shadow_presc = '0;
          t = shadow_ttl[shadow_ptr];
          if (t != 8'd0) begin
            shadow_ttl[shadow_ptr] = (t >= shadow_step) ? t - shadow_step : 8'd0;
          end
          shadow_ptr = shadow_ptr + ADDR_W'(1);
        end
        return 1'b0;
      end
      MODE_QUERY: begin
        if (shadow_ttl[rq.node] != 8'd0) begin
          r.hit = 1'b1;
          r.cur = 15'(shadow_cur[rq.node] * 100);
          r.volt = 16'(shadow_volt[rq.node] * 100);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_request(req_row_t rq);
    reply_t r;
    start <= 1'b1;
    mode <= rq.mode;
    node_id <= rq.node;
    current_raw <= rq.cur;
    voltage_raw <= rq.volt;
    packet_type <= rq.ptype;
    do @(posedge clk); while (busy);
    if (cache_update(rq, r)) begin
      pending_replies.push_back(rq.typed ? rq.want : r);
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TTL_INITIAL: shadow_ttl_init = val[7:0];
      CFG_TTL_STEP:    shadow_step = val[7:0];
      CFG_TICK_DIVIDE: shadow_div = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [9:0] ttl_init, logic [9:0] step, logic [9:0] div);
    write_register(CFG_TTL_INITIAL, ttl_init);
    write_register(CFG_TTL_STEP, step);
    write_register(CFG_TICK_DIVIDE, div);
    cfg_valid <= 1'b0;
  endtask

  // Holds requests off until every reply is in and the last write-back is done.
  task automatic settle();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic maybe_idle(bit idle_on);
    if (idle_on && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic req_row_t random_request();
    int pick;
    logic [1:0] m;
    logic [6:0] id;
    logic [7:0] t;
    pick = $urandom_range(0, 99);
    if (pick < 35) m = MODE_STORE;
    else if (pick < 65) m = MODE_TICK;
    else if (pick < 95) m = MODE_QUERY;
    else m = MODE_UNUSED;
    id = $urandom_range(0, 1) ? 7'($urandom_range(0, 15)) : 7'($urandom_range(0, 127));
    t = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : PACKET_TYPE_DATA;
    return row(m, id, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), t);
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply for node %0d", node_id_out);
        fault_count++;
      end else begin
        want = pending_replies.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          fault_count++;
        end
        if (node_id_out !== want.node) begin
          $error("node_id_out: expected %0d, got %0d", want.node, node_id_out);
          fault_count++;
        end
        if (current_scaled !== want.cur) begin
          $error("current_scaled: expected %0d, got %0d", want.cur, current_scaled);
          fault_count++;
        end
        if (voltage_scaled !== want.volt) begin
          $error("voltage_scaled: expected %0d, got %0d", want.volt, voltage_scaled);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_STORE;
    node_id <= '0;
    current_raw <= '0;
    voltage_raw <= '0;
    packet_type <= PACKET_TYPE_DATA;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TTL_INITIAL;
    cfg_data <= '0;
    fault_count = 0;
    idle_cycles = 0;
    foreach (shadow_ttl[i]) begin
      shadow_ttl[i] = '0;
      shadow_cur[i] = '0;
      shadow_volt[i] = '0;
    end
    shadow_ptr = '0;
    shadow_presc = '0;
    shadow_ttl_init = TTL_INITIAL_RESET;
    shadow_step = TTL_STEP_RESET;
    shadow_div = TICK_DIVIDE_RESET;

    script = '{
      row(MODE_QUERY, 7'd0, 16'd0, 16'd0, 8'h00, 1'b1),
      row(MODE_QUERY, 7'd127, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1),
      row(MODE_STORE, 7'd0, 16'hFFFF, 16'hFFFF, PACKET_TYPE_DATA),
      row(MODE_QUERY, 7'd0, 16'd0, 16'd0, 8'h00, 1'b1, 1'b1, 15'd14300, 16'd65500),
      row(MODE_STORE, 7'd127, 16'd0, 16'd0, PACKET_TYPE_DATA),
      row(MODE_QUERY, 7'd127, 16'd0, 16'd0, 8'h00, 1'b1, 1'b1, 15'd0, 16'd0),
      row(MODE_STORE, 7'd5, 16'd12345, 16'd23456, 8'hFF),
      row(MODE_QUERY, 7'd5, 16'd0, 16'd0, 8'h00, 1'b1),
      row(MODE_STORE, 7'd5, 16'd12345, 16'd23456, 8'h01),
      row(MODE_QUERY, 7'd5, 16'd0, 16'd0, 8'h00, 1'b1),
      row(MODE_UNUSED, 7'd0, 16'hFFFF, 16'hFFFF, 8'hFF),
      row(MODE_STORE, 7'd1, 16'd99, 16'd100, PACKET_TYPE_DATA),
      row(MODE_QUERY, 7'd1, 16'd0, 16'd0, 8'h00),
      row(MODE_STORE, 7'd2, 16'd25599, 16'd25600, PACKET_TYPE_DATA),
      row(MODE_QUERY, 7'd2, 16'd0, 16'd0, 8'h00),
      row(MODE_STORE, 7'd3, 16'd25600, 16'd65499, PACKET_TYPE_DATA),
      row(MODE_QUERY, 7'd3, 16'd0, 16'd0, 8'h00),
      row(MODE_TICK, 7'd0, 16'd0, 16'd0, 8'h00),
      row(MODE_TICK, 7'd127, 16'hFFFF, 16'hFFFF, 8'hFF),
      row(MODE_QUERY, 7'd0, 16'd0, 16'd0, 8'h00, 1'b1, 1'b1, 15'd14300, 16'd65500),
      row(MODE_STORE, 7'd64, 16'd5000, 16'd5000, 8'h80),
      row(MODE_QUERY, 7'd64, 16'd0, 16'd0, 8'h00, 1'b1)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_request(script[i]);
      maybe_idle(1'b1);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: set_registers(10'd255, 10'd1, 10'd1);
          2: set_registers(10'h300, 10'd255, 10'd1023);
          3: set_registers(10'd1, 10'd0, 10'd2);
          4: set_registers(10'd100, 10'd30, 10'd0);
          default: set_registers(10'($urandom_range(1, 255)), 10'($urandom_range(1, 255)),
                                 10'($urandom_range(1, 6)));
        endcase
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 5 && n == 40) begin
          settle();
        end
        send_request(random_request());
        maybe_idle(p != 3);
      end
    end

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rcttl_pkg.sv
rtl/core/rcttl_mem.sv
rtl/core/reading_cache_with_ttl_aging.sv
rtl/core/rcttl_checker.sv
test/reading_cache_with_ttl_aging_tb.sv
